### hw/rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and index helpers for the toroidal life-cell
// stepper: grid geometry, operation codes and the command queue entry.
// ----------------------------------------------------------------------------
package lcs_pkg;

    // Grid geometry
    localparam int GRID_SIDE = 128;
    localparam int IDX_W     = $clog2(GRID_SIDE);
    localparam int COORD_W   = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int                 APB_ADDR_W = 3;
    localparam int                 APB_DATA_W = 32;
    localparam logic               REG_RCO    = 1'b0;   // word index of the report-mode register

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [GRID_SIDE-1:0] row_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_EVAL   = 2'd1,
        OP_COMMIT = 2'd2
    } op_t;

    // One classified command waiting for the back end
    typedef struct packed {
        op_t    op;
        coord_t x;
        coord_t y;
        logic   wval;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WR_MOD,
        BK_EV_ABOVE,
        BK_EV_MID,
        BK_EV_BELOW
    } back_state_t;

    function automatic idx_t to_idx(input coord_t c);
        return IDX_W'(c);
    endfunction

    function automatic idx_t idx_prev(input idx_t i);
        return (i == '0) ? IDX_W'(GRID_SIDE - 1) : i - 1'b1;
    endfunction

    function automatic idx_t idx_next(input idx_t i);
        return (i == IDX_W'(GRID_SIDE - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

### hw/rtl/life_cell_step_torus.sv
// ----------------------------------------------------------------------------
// life_cell_step_torus
// Game of Life (B3/S23) stepper on a toroidal grid held in two row-wide
// buffers, with an APB register for changes-only reporting.
// ----------------------------------------------------------------------------
// Results: a result strobes on done once its evaluate has passed through the
// queue and the back-end states; the receiver cannot stall results.
// Work per command: an evaluate makes three row reads through the single port
// of the current-grid memory, a write reads and rewrites its row, a commit swaps.
// A two-entry command queue lets start be taken while the back end works.
// Reset: grids read as all dead at once through per-row written flags;
// no clearing pass. Buffer a is current and changes-only mode is off.
module life_cell_step_torus
    import lcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            opcode,
    input  coord_t                cell_x,
    input  coord_t                cell_y,
    input  logic                  write_live,
    output logic                  done,
    output coord_t                out_x,
    output coord_t                out_y,
    output logic                  new_state,
    output logic                  changed
);

    logic rco_reg;
    logic cfg_wr;
    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic q_empty;
    logic q_full;

    // Register write and read back
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RCO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rco_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            rco_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_RCO) ? {{(APB_DATA_W-1){1'b0}}, rco_reg} : '0;

    assign busy = q_full;

    lcs_front u_front (
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .write_live (write_live),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    lcs_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    lcs_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .report_flips_only (rco_reg),
        .head              (head),
        .empty             (q_empty),
        .pop               (pop),
        .done              (done),
        .out_x             (out_x),
        .out_y             (out_y),
        .new_state         (new_state),
        .changed           (changed)
    );

endmodule

### hw/rtl/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram
// Generic single-port RAM: one access per cycle, write or read, with the
// read data registered.
// ----------------------------------------------------------------------------
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write or read the addressed word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lcs_front.sv
// ----------------------------------------------------------------------------
// lcs_front
// Accepts operations and classifies them: drops unused codes and cells off
// the grid, and turns the rest into queue commands.
// ----------------------------------------------------------------------------
module lcs_front
    import lcs_pkg::*;
(
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  coord_t      cell_x,
    input  coord_t      cell_y,
    input  logic        write_live,
    output logic        push,
    output cmd_t        push_cmd
);

    logic accept;
    logic on_grid;

    assign accept  = start && !busy;
    assign on_grid = (int'(cell_x) < GRID_SIDE) && (int'(cell_y) < GRID_SIDE);

    // Classify the accepted transaction
    always_comb
    begin
        push          = 1'b0;
        push_cmd.op   = OP_COMMIT;
        push_cmd.x    = cell_x;
        push_cmd.y    = cell_y;
        push_cmd.wval = write_live;
        unique case (opcode)
            OP_WRITE:
            begin
                push_cmd.op = OP_WRITE;
                push        = accept && on_grid;
            end
            OP_EVAL:
            begin
                push_cmd.op = OP_EVAL;
                push        = accept && on_grid;
            end
            OP_COMMIT:
            begin
                push_cmd.op = OP_COMMIT;
                push        = accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/lcs_cmd_queue.sv
// ----------------------------------------------------------------------------
// lcs_cmd_queue
// Short command FIFO that decouples the front from the back end.
// ----------------------------------------------------------------------------
module lcs_cmd_queue
    import lcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/lcs_back.sv
// ----------------------------------------------------------------------------
// lcs_back
// Carries out queued commands on the two row-wide grid memories: cell
// writes, neighborhood evaluation into the next grid, and buffer swaps.
// ----------------------------------------------------------------------------
module lcs_back
    import lcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   report_flips_only,
    input  cmd_t   head,
    input  logic   empty,
    output logic   pop,
    output logic   done,
    output coord_t out_x,
    output coord_t out_y,
    output logic   new_state,
    output logic   changed
);

    back_state_t state_reg;
    back_state_t state_next;

    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic sel_reg;
    logic sel_next;

    // Per-row written flags; an unwritten row reads as all dead
    row_t valid_a_reg;
    row_t valid_a_next;
    row_t valid_b_reg;
    row_t valid_b_next;
    logic a_rv_reg;
    logic b_rv_reg;

    row_t above_reg;
    row_t above_next;
    row_t mid_reg;
    row_t mid_next;
    row_t nrow_reg;
    row_t nrow_next;

    logic   res_valid_reg;
    logic   res_valid_next;
    coord_t res_x_reg;
    coord_t res_x_next;
    coord_t res_y_reg;
    coord_t res_y_next;
    logic   res_state_reg;
    logic   res_state_next;
    logic   res_changed_reg;
    logic   res_changed_next;

    // Logical current / next memory ports
    idx_t cur_addr;
    logic cur_we;
    row_t cur_wdata;
    idx_t nxt_addr;
    logic nxt_we;
    row_t nxt_wdata;

    idx_t a_addr;
    logic a_we;
    row_t a_wdata;
    row_t a_rdata;
    idx_t b_addr;
    logic b_we;
    row_t b_wdata;
    row_t b_rdata;

    row_t cur_rd;
    row_t nxt_rd;

    idx_t cx;
    idx_t cy;
    idx_t xm;
    idx_t xp;
    logic [3:0] nbr_cnt;
    logic       old_state;
    logic       nst;

    // Map current/next onto buffers a and b
    assign a_addr  = sel_reg ? nxt_addr  : cur_addr;
    assign a_we    = sel_reg ? nxt_we    : cur_we;
    assign a_wdata = sel_reg ? nxt_wdata : cur_wdata;
    assign b_addr  = sel_reg ? cur_addr  : nxt_addr;
    assign b_we    = sel_reg ? cur_we    : nxt_we;
    assign b_wdata = sel_reg ? cur_wdata : nxt_wdata;

    lcs_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (GRID_SIDE)
    ) u_grid_a (
        .clk   (clk),
        .we    (a_we),
        .addr  (a_addr),
        .wdata (a_wdata),
        .rdata (a_rdata)
    );

    lcs_ram #(
        .WIDTH (GRID_SIDE),
        .DEPTH (GRID_SIDE)
    ) u_grid_b (
        .clk   (clk),
        .we    (b_we),
        .addr  (b_addr),
        .wdata (b_wdata),
        .rdata (b_rdata)
    );

    // Mask rows never written since reset
    always_comb
    begin
        if (sel_reg)
        begin
            cur_rd = b_rdata & {GRID_SIDE{b_rv_reg}};
            nxt_rd = a_rdata & {GRID_SIDE{a_rv_reg}};
        end
        else
        begin
            cur_rd = a_rdata & {GRID_SIDE{a_rv_reg}};
            nxt_rd = b_rdata & {GRID_SIDE{b_rv_reg}};
        end
    end

    // Count the eight wrapped neighbors from the three gathered rows
    assign cx = to_idx(cmd_reg.x);
    assign cy = to_idx(cmd_reg.y);
    assign xm = idx_prev(cx);
    assign xp = idx_next(cx);

    assign nbr_cnt = 4'(above_reg[xm]) + 4'(above_reg[cx]) + 4'(above_reg[xp])
                   + 4'(mid_reg[xm])   + 4'(mid_reg[xp])
                   + 4'(cur_rd[xm])    + 4'(cur_rd[cx])    + 4'(cur_rd[xp]);
    assign old_state = mid_reg[cx];
    assign nst       = (nbr_cnt == 4'd3) || (old_state && (nbr_cnt == 4'd2));

    // Sequence the command
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        sel_next         = sel_reg;
        valid_a_next     = valid_a_reg;
        valid_b_next     = valid_b_reg;
        above_next       = above_reg;
        mid_next         = mid_reg;
        nrow_next        = nrow_reg;
        res_valid_next   = 1'b0;
        res_x_next       = res_x_reg;
        res_y_next       = res_y_reg;
        res_state_next   = res_state_reg;
        res_changed_next = res_changed_reg;
        pop              = 1'b0;
        cur_addr         = cy;
        cur_we           = 1'b0;
        cur_wdata        = cur_rd;
        nxt_addr         = cy;
        nxt_we           = 1'b0;
        nxt_wdata        = nrow_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                cur_addr = to_idx(head.y);
                nxt_addr = to_idx(head.y);
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.op)
                        OP_WRITE:
                        begin
                            state_next = BK_WR_MOD;
                        end
                        OP_EVAL:
                        begin
                            cur_addr   = idx_prev(to_idx(head.y));
                            state_next = BK_EV_ABOVE;
                        end
                        OP_COMMIT:
                        begin
                            sel_next = !sel_reg;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end

            BK_WR_MOD:
            begin
                cur_we        = 1'b1;
                cur_wdata     = cur_rd;
                cur_wdata[cx] = cmd_reg.wval;
                if (sel_reg)
                begin
                    valid_b_next[cy] = 1'b1;
                end
                else
                begin
                    valid_a_next[cy] = 1'b1;
                end
                state_next = BK_IDLE;
            end

            BK_EV_ABOVE:
            begin
                above_next = cur_rd;
                nrow_next  = nxt_rd;
                cur_addr   = cy;
                state_next = BK_EV_MID;
            end

            BK_EV_MID:
            begin
                mid_next   = cur_rd;
                cur_addr   = idx_next(cy);
                state_next = BK_EV_BELOW;
            end

            BK_EV_BELOW:
            begin
                nxt_we        = 1'b1;
                nxt_wdata     = nrow_reg;
                nxt_wdata[cx] = nst;
                if (sel_reg)
                begin
                    valid_a_next[cy] = 1'b1;
                end
                else
                begin
                    valid_b_next[cy] = 1'b1;
                end
                res_valid_next   = (nst != old_state) || (nst && !report_flips_only);
                res_x_next       = cmd_reg.x;
                res_y_next       = cmd_reg.y;
                res_state_next   = nst;
                res_changed_next = (nst != old_state);
                state_next       = BK_IDLE;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sel_reg       <= 1'b0;
            valid_a_reg   <= '0;
            valid_b_reg   <= '0;
            a_rv_reg      <= 1'b0;
            b_rv_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            valid_a_reg   <= valid_a_next;
            valid_b_reg   <= valid_b_next;
            a_rv_reg      <= valid_a_reg[a_addr];
            b_rv_reg      <= valid_b_reg[b_addr];
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold command, gathered rows and result payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        above_reg       <= above_next;
        mid_reg         <= mid_next;
        nrow_reg        <= nrow_next;
        res_x_reg       <= res_x_next;
        res_y_reg       <= res_y_next;
        res_state_reg   <= res_state_next;
        res_changed_reg <= res_changed_next;
    end

    assign done      = res_valid_reg;
    assign out_x     = res_x_reg;
    assign out_y     = res_y_reg;
    assign new_state = res_state_reg;
    assign changed   = res_changed_reg;

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for life_cell_step_torus
// Drives write, evaluate and commit commands plus the changes-only register.
// Small live patterns are seeded near the wrap edges and stepped for a few
// generations, with random noise commands mixed in. A scoreboard keeps its
// own copy of both grid buffers and checks every reported cell in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              SIDE        = GRID_SIDE;
    localparam logic [1:0]      OP_UNUSED   = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_FLIPS_ONLY = APB_ADDR_W'(int'(REG_RCO) * 4);
    localparam int              DRAIN_CYCLES = 30;
    localparam int              CYCLE_LIMIT  = 400000;
    localparam int              PHASE_ITEMS  = 360;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   live;
        logic   flip;
    } cell_report_t;

    // Own model of the two grid buffers and the reports they cause
    class life_scoreboard;
        bit [SIDE-1:0] cells[2][SIDE];
        bit            cur_sel;
        bit            flips_only;
        cell_report_t  pending_reports[$];
        int            mismatches;

        function new();
            for (int b = 0; b < 2; b++)
                for (int r = 0; r < SIDE; r++)
                    cells[b][r] = '0;
            cur_sel    = 1'b0;
            flips_only = 1'b0;
            mismatches = 0;
        endfunction

        function void set_flips_only(bit v);
            flips_only = v;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // Apply one accepted transaction and queue the report it causes
        function void note_command(logic [1:0] op, coord_t x, coord_t y, logic wl);
            int           count;
            int           r;
            int           c;
            bit           old_live;
            bit           next_live;
            cell_report_t rep;
            if (op == OP_COMMIT)
            begin
                cur_sel = ~cur_sel;
                return;
            end
            if (op == OP_UNUSED)
                return;
            if (int'(x) >= SIDE || int'(y) >= SIDE)
                return;
            if (op == OP_WRITE)
            begin
                cells[cur_sel][y][x] = wl;
                return;
            end
            // Count the eight wrapped neighbors in the current grid
            count = 0;
            for (int dy = -1; dy <= 1; dy++)
            begin
                for (int dx = -1; dx <= 1; dx++)
                begin
                    if (dx == 0 && dy == 0)
                        continue;
                    r = (int'(y) + dy + SIDE) % SIDE;
                    c = (int'(x) + dx + SIDE) % SIDE;
                    count += cells[cur_sel][r][c];
                end
            end
            old_live  = cells[cur_sel][y][x];
            next_live = old_live ? (count == 2 || count == 3) : (count == 3);
            cells[~cur_sel][y][x] = next_live;
            if (next_live != old_live || (next_live && !flips_only))
            begin
                rep.x    = x;
                rep.y    = y;
                rep.live = next_live;
                rep.flip = (next_live != old_live);
                pending_reports.push_back(rep);
            end
        endfunction

        // Compare one reported cell with the oldest expected report
        function void check_report(coord_t x, coord_t y, logic live, logic flip);
            cell_report_t exp_rep;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected report at (%0d,%0d) state %0d changed %0d",
                       x, y, live, flip);
                mismatches++;
                return;
            end
            exp_rep = pending_reports.pop_front();
            if (x !== exp_rep.x)
            begin
                $error("out_x mismatch: expected %0d, actual %0d", exp_rep.x, x);
                mismatches++;
            end
            if (y !== exp_rep.y)
            begin
                $error("out_y mismatch: expected %0d, actual %0d", exp_rep.y, y);
                mismatches++;
            end
            if (live !== exp_rep.live)
            begin
                $error("new_state mismatch: expected %0d, actual %0d", exp_rep.live, live);
                mismatches++;
            end
            if (flip !== exp_rep.flip)
            begin
                $error("changed mismatch: expected %0d, actual %0d", exp_rep.flip, flip);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [1:0]            opcode;
    coord_t                cell_x;
    coord_t                cell_y;
    logic                  write_live;
    logic                  done;
    coord_t                out_x;
    coord_t                out_y;
    logic                  new_state;
    logic                  changed;

    life_scoreboard board = new();
    int             items_sent;
    int             idle_pct;
    int             cycle_count;

    life_cell_step_torus DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .write_live (write_live),
        .done       (done),
        .out_x      (out_x),
        .out_y      (out_y),
        .new_state  (new_state),
        .changed    (changed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Watch both sides of the block at every edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_report(out_x, out_y, new_state, changed);
            if (start && !busy)
                board.note_command(opcode, cell_x, cell_y, write_live);
        end
    end

    // Write the changes-only register through a setup phase and an access phase
    task automatic write_flips_only(bit v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FLIPS_ONLY;
        pwdata  <= APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.set_flips_only(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Present one transaction, hold it until taken, then maybe idle
    task automatic send(logic [1:0] op, coord_t x, coord_t y, logic wl);
        start      <= 1'b1;
        opcode     <= op;
        cell_x     <= x;
        cell_y     <= y;
        write_live <= wl;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic send_noise();
        send(2'($urandom_range(0, 3)), coord_t'($urandom_range(0, 127)),
             coord_t'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
    endtask

    // Seed a small patch, often across a wrap edge, and step it a few times
    task automatic run_patch();
        coord_t bx;
        coord_t by;
        int     w;
        int     density;
        int     gens;
        case ($urandom_range(0, 3))
            0:       bx = coord_t'(127);
            1:       bx = coord_t'(0);
            default: bx = coord_t'($urandom_range(0, 127));
        endcase
        case ($urandom_range(0, 3))
            0:       by = coord_t'(127);
            1:       by = coord_t'(0);
            default: by = coord_t'($urandom_range(0, 127));
        endcase
        w       = ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(2, 4);
        density = $urandom_range(25, 60);
        gens    = $urandom_range(1, 3);
        for (int j = 0; j < w; j++)
            for (int i = 0; i < w; i++)
                send(OP_WRITE, coord_t'(bx + i), coord_t'(by + j),
                     ($urandom_range(99) < density));
        repeat (gens)
        begin
            for (int j = -1; j <= w; j++)
            begin
                for (int i = -1; i <= w; i++)
                begin
                    // Skip a few cells so stale next-buffer values survive
                    if ($urandom_range(99) < 5)
                        continue;
                    if ($urandom_range(99) < 4)
                        send_noise();
                    send(OP_EVAL, coord_t'(bx + i), coord_t'(by + j),
                         1'($urandom_range(0, 1)));
                end
            end
            send(OP_COMMIT, coord_t'($urandom_range(0, 127)),
                 coord_t'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait out every expected report and any silent transaction still in flight
    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int pct_by_phase[4];
        bit cfg_by_phase[4];
        int target;
        pct_by_phase = '{0, 83, 0, 27};
        cfg_by_phase = '{1'b0, 1'b1, 1'b0, 1'b1};
        items_sent   = 0;
        idle_pct     = 0;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        start      <= 1'b0;
        opcode     <= OP_WRITE;
        cell_x     <= '0;
        cell_y     <= '0;
        write_live <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: blinker across the left/right edge, births across top/bottom
        send(OP_WRITE, 7'd127, 7'd0, 1'b1);
        send(OP_WRITE, 7'd0,   7'd0, 1'b1);
        send(OP_WRITE, 7'd1,   7'd0, 1'b1);
        send(OP_EVAL,  7'd0,   7'd0, 1'b0);
        send(OP_EVAL,  7'd0,   7'd127, 1'b1);
        send(OP_EVAL,  7'd0,   7'd1, 1'b0);
        send(OP_EVAL,  7'd127, 7'd0, 1'b0);
        send(OP_EVAL,  7'd1,   7'd0, 1'b1);
        send(OP_EVAL,  7'd64,  7'd64, 1'b0);
        send(OP_UNUSED, 7'd127, 7'd127, 1'b1);
        send(OP_COMMIT, 7'd0, 7'd0, 1'b0);
        send(OP_EVAL,  7'd0,   7'd0, 1'b0);
        send(OP_EVAL,  7'd1,   7'd1, 1'b0);
        send(OP_EVAL,  7'd127, 7'd127, 1'b0);
        send(OP_WRITE, 7'd127, 7'd127, 1'b1);
        send(OP_WRITE, 7'd127, 7'd127, 1'b0);
        send(OP_EVAL,  7'd127, 7'd127, 1'b1);
        send(OP_EVAL,  7'd0,   7'd127, 1'b0);
        send(OP_COMMIT, 7'd127, 7'd127, 1'b1);
        send(OP_EVAL,  7'd0,   7'd0, 1'b1);

        // Random phases, each with its own idle rate and register setting
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_flips_only(cfg_by_phase[ph]);
            @(posedge clk);
            idle_pct = pct_by_phase[ph];
            target   = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 15)
                    send_noise();
                else
                    run_patch();
            end
        end
        drain();

        if (board.pending() != 0)
        begin
            $error("%0d expected reports never arrived", board.pending());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
